// ===== src/lsfb_pkg.sv =====
// Shared types and constants for the LED strip frame buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package lsfb_pkg;

  localparam int ChanW  = 8;
  localparam int PixelW = 3 * ChanW;
  localparam int CountW = 7;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [ChanW-1:0]  BrightnessReset = 8'd255;
  localparam logic [CountW-1:0] PixelCountReset = 7'd64;

  // Register select is paddr bit 2 (registers at byte addresses 0 and 4).
  localparam int  RegSelBit       = 2;
  localparam logic REG_BRIGHTNESS  = 1'b0;
  localparam logic REG_PIXEL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SHOW  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SHOW = 2'b10
  } state_e;

  typedef struct packed {
    logic wr;    // store the input pixel
    logic clr;   // black out every entry
    logic rd;    // read slot carries a shown pixel
    logic last;  // that pixel ends the run
  } dp_cmd_t;

  typedef struct packed {
    logic adv;   // pipeline advances this cycle
  } dp_status_t;

endpackage

// ===== src/lsfb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lsfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lsfb_ctrl.sv =====
// Controller for the LED strip frame buffer: takes input transfers and
// sequences the show run. Depends on lsfb_pkg.
module lsfb_ctrl #(
  parameter int MaxPixels = 64,
  localparam int IdxW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1,
  localparam int CntW = $clog2(MaxPixels + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [7:0]            pixel_index_i,
  input  logic [CntW-1:0]       used_count_i,
  input  lsfb_pkg::dp_status_t  status_i,
  output lsfb_pkg::dp_cmd_t     cmd_o,
  output logic [IdxW-1:0]       rd_idx_o
);

  lsfb_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  last_idx;
  logic             at_last;
  logic             accept;
  lsfb_pkg::mode_e  mode;

  assign mode     = lsfb_pkg::mode_e'(mode_i);
  assign last_idx = used_count_i - CntW'(1);
  assign at_last  = (CntW'(idx_q) == last_idx);
  assign accept   = in_valid_i && in_ready_o;

  assign in_ready_o = (state_q == lsfb_pkg::ST_IDLE);
  assign rd_idx_o   = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      lsfb_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode)
            lsfb_pkg::MODE_WRITE: cmd_o.wr = (pixel_index_i < 8'(used_count_i));
            lsfb_pkg::MODE_CLEAR: cmd_o.clr = 1'b1;
            lsfb_pkg::MODE_SHOW: begin
              if (used_count_i != '0) begin
                state_d = lsfb_pkg::ST_SHOW;
                idx_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      lsfb_pkg::ST_SHOW: begin
        cmd_o.rd   = 1'b1;
        cmd_o.last = at_last;
        // advance only when the read slot is taken by the pipeline
        if (status_i.adv) begin
          if (at_last) begin
            state_d = lsfb_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: state_d = lsfb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsfb_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== src/lsfb_dp.sv =====
// Datapath for the LED strip frame buffer: pixel RAM with valid bits,
// brightness scaling pipeline and output register. Depends on lsfb_pkg, lsfb_ram.
module lsfb_dp #(
  parameter int MaxPixels = 64,
  localparam int IdxW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lsfb_pkg::dp_cmd_t                cmd_i,
  output lsfb_pkg::dp_status_t             status_o,
  input  logic [IdxW-1:0]                  rd_idx_i,
  input  logic [IdxW-1:0]                  wr_idx_i,
  input  logic [lsfb_pkg::ChanW-1:0]       red_i,
  input  logic [lsfb_pkg::ChanW-1:0]       green_i,
  input  logic [lsfb_pkg::ChanW-1:0]       blue_i,
  input  logic [lsfb_pkg::ChanW-1:0]       brightness_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lsfb_pkg::PixelW-1:0]      out_data_o,
  output logic                             out_last_o
);

  localparam int CW = lsfb_pkg::ChanW;
  localparam int PW = 2 * CW;

  // floor(x / 255) for any x up to 255 * 255, the largest channel product
  function automatic logic [CW-1:0] div255(input logic [PW-1:0] x);
    logic [PW:0] t;
    t = {1'b0, x} + (PW+1)'(x[PW-1:CW]) + (PW+1)'(1);
    return t[PW-1:CW];
  endfunction

  logic                    en;
  logic [MaxPixels-1:0]    valid_q;
  logic [3*CW-1:0]         rdata;
  logic [3*CW-1:0]         pix;
  logic                    s1_vld_q, s1_last_q, s1_hit_q;
  logic                    s2_vld_q, s2_last_q;
  logic [PW-1:0]           prod_g_q, prod_r_q, prod_b_q;
  logic                    out_vld_q, out_last_q;
  logic [3*CW-1:0]         out_data_q;

  assign en           = !out_vld_q || out_ready_i;
  assign status_o.adv = en;

  lsfb_ram #(
    .Width(3 * CW),
    .Depth(MaxPixels)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(wr_idx_i),
    .wdata_i({green_i, red_i, blue_i}),
    .re_i   (en),
    .raddr_i(rd_idx_i),
    .rdata_o(rdata)
  );

  // Entries never written since reset or clear read as black.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clr) begin
      valid_q <= '0;
    end else if (cmd_i.wr) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  assign pix = s1_hit_q ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= cmd_i.rd;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_last_q  <= cmd_i.last;
      s1_hit_q   <= valid_q[rd_idx_i];
      s2_last_q  <= s1_last_q;
      prod_g_q   <= PW'(pix[3*CW-1:2*CW]) * PW'(brightness_i);
      prod_r_q   <= PW'(pix[2*CW-1:CW]) * PW'(brightness_i);
      prod_b_q   <= PW'(pix[CW-1:0]) * PW'(brightness_i);
      out_last_q <= s2_last_q;
      out_data_q <= {div255(prod_g_q), div255(prod_r_q), div255(prod_b_q)};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== src/led_strip_frame_buffer_core.sv =====
// LED strip frame buffer: write, clear and show items on a stream, GRB words out.
// Write and clear leave the input ready. A show of n pixels holds off the input
// until its last pixel enters the read pipeline and emits one pixel per cycle while
// the output is not stalled; a stalled output holds the whole read pipeline.
// Reset: brightness 255, pixel count 64, every entry reads black (valid bits
// clear at once, no RAM clearing pass). Depends on lsfb_pkg, lsfb_ctrl, lsfb_dp.
module led_strip_frame_buffer_core #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // pixel_index, red, green, blue
  input  logic [1:0]                    s_axis_tuser,  // mode
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // grb_word
  output logic                          m_axis_tlast,  // last_pixel
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsfb_pkg::ApbAddrW-1:0] paddr,
  input  logic [lsfb_pkg::ApbDataW-1:0] pwdata,
  output logic [lsfb_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int IdxW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CntW = $clog2(MAX_PIXELS + 1);
  localparam logic [lsfb_pkg::CountW-1:0] MaxCount = lsfb_pkg::CountW'(MAX_PIXELS);

  logic [lsfb_pkg::ChanW-1:0]  brightness_q;
  logic [lsfb_pkg::CountW-1:0] pixel_count_q;
  logic [CntW-1:0]             used_count;
  logic                        cfg_wr;
  logic                        reg_sel;
  logic [IdxW-1:0]             rd_idx;
  lsfb_pkg::dp_cmd_t           cmd;
  lsfb_pkg::dp_status_t        status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[lsfb_pkg::RegSelBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q  <= lsfb_pkg::BrightnessReset;
      pixel_count_q <= lsfb_pkg::PixelCountReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lsfb_pkg::REG_BRIGHTNESS:  brightness_q  <= pwdata[lsfb_pkg::ChanW-1:0];
        lsfb_pkg::REG_PIXEL_COUNT: pixel_count_q <= pwdata[lsfb_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lsfb_pkg::REG_BRIGHTNESS:  prdata = lsfb_pkg::ApbDataW'(brightness_q);
      lsfb_pkg::REG_PIXEL_COUNT: prdata = lsfb_pkg::ApbDataW'(pixel_count_q);
      default:                   prdata = '0;
    endcase
  end

  // saturate the programmed count to the store depth
  assign used_count = (pixel_count_q > MaxCount) ? CntW'(MAX_PIXELS)
                                                 : pixel_count_q[CntW-1:0];

  lsfb_ctrl #(
    .MaxPixels(MAX_PIXELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tuser),
    .pixel_index_i(s_axis_tdata[7:0]),
    .used_count_i (used_count),
    .status_i     (status),
    .cmd_o        (cmd),
    .rd_idx_o     (rd_idx)
  );

  lsfb_dp #(
    .MaxPixels(MAX_PIXELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .rd_idx_i    (rd_idx),
    .wr_idx_i    (s_axis_tdata[IdxW-1:0]),
    .red_i       (s_axis_tdata[15:8]),
    .green_i     (s_axis_tdata[23:16]),
    .blue_i      (s_axis_tdata[31:24]),
    .brightness_i(brightness_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef SYNTH
  a_show_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == lsfb_pkg::MODE_SHOW
     && used_count != '0) |=> !s_axis_tready)
    else $error("show transfer did not start a run");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (CntW'(rd_idx) < used_count))
    else $error("read index beyond pixel count");

  a_stall_holds_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && !s_axis_tready) |=> $stable(rd_idx))
    else $error("read index moved while output stalled");
`endif

endmodule
